[design/button_rgb_led_dimmer_assert.svh]
// Assertion macros for the dimmer checker
`ifndef BUTTON_RGB_LED_DIMMER_ASSERT_SVH
`define BUTTON_RGB_LED_DIMMER_ASSERT_SVH

// same-cycle implication, masked during reset
`define BRD_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("dimmer check failed");

// next-cycle implication, masked during reset
`define BRD_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("dimmer check failed");

`endif

[design/brd_pkg.sv]
package brd_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_PWM_PERIOD       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ON_TIME_LOW      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ON_TIME_MID      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ON_TIME_HIGH     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_PERIODS = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_PERIODS     = 3'd5;

   localparam logic [7:0] RST_PWM_PERIOD       = 8'd22;
   localparam logic [7:0] RST_ON_TIME_LOW      = 8'd2;
   localparam logic [7:0] RST_ON_TIME_MID      = 8'd12;
   localparam logic [7:0] RST_ON_TIME_HIGH     = 8'd20;
   localparam logic [5:0] RST_DEBOUNCE_PERIODS = 6'd3;
   localparam logic [5:0] RST_HOLD_PERIODS     = 6'd45;

   localparam logic [7:0] PERIOD_MIN = 8'd2;
   localparam logic [5:0] COUNT_MAX  = 6'd63;

   localparam logic [1:0] COLOR_RED   = 2'd0;
   localparam logic [1:0] COLOR_GREEN = 2'd1;
   localparam logic [1:0] COLOR_BLUE  = 2'd2;

   localparam logic [1:0] LEVEL_LOW  = 2'd0;
   localparam logic [1:0] LEVEL_MID  = 2'd1;
   localparam logic [1:0] LEVEL_HIGH = 2'd2;

   typedef struct packed {
      logic [7:0] pwm_period;
      logic [7:0] on_time_low;
      logic [7:0] on_time_mid;
      logic [7:0] on_time_high;
      logic [5:0] debounce_periods;
      logic [5:0] hold_periods;
   } cfg_type;

   typedef struct packed {
      logic       red_on;
      logic       green_on;
      logic       blue_on;
      logic       out_lit;
      logic [1:0] out_color;
      logic [1:0] out_level;
   } result_type;

endpackage

[design/brd_csr.sv]
module brd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [brd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [brd_pkg::CSR_DATA_W-1:0]  csr_data,
   output brd_pkg::cfg_type               cfg
);
   import brd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PWM_PERIOD:       cfg_in.pwm_period       = csr_data;
            CSR_ON_TIME_LOW:      cfg_in.on_time_low      = csr_data;
            CSR_ON_TIME_MID:      cfg_in.on_time_mid      = csr_data;
            CSR_ON_TIME_HIGH:     cfg_in.on_time_high     = csr_data;
            CSR_DEBOUNCE_PERIODS: cfg_in.debounce_periods = csr_data[5:0];
            CSR_HOLD_PERIODS:     cfg_in.hold_periods     = csr_data[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pwm_period       <= RST_PWM_PERIOD;
         cfg_ff.on_time_low      <= RST_ON_TIME_LOW;
         cfg_ff.on_time_mid      <= RST_ON_TIME_MID;
         cfg_ff.on_time_high     <= RST_ON_TIME_HIGH;
         cfg_ff.debounce_periods <= RST_DEBOUNCE_PERIODS;
         cfg_ff.hold_periods     <= RST_HOLD_PERIODS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[design/brd_core.sv]
module brd_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic                button_down,
   input  brd_pkg::cfg_type    cfg,
   output brd_pkg::result_type result
);
   import brd_pkg::*;

   logic [1:0] color_ff, color_in;
   logic [1:0] level_ff, level_in;
   logic       lit_ff, lit_in;
   logic [7:0] phase_ff, phase_in;
   logic [5:0] count_ff, count_in;
   logic       in_press_ff, in_press_in;
   logic       accepted_ff, accepted_in;
   logic       settled_ff, settled_in;
   logic       lit_at_press_ff, lit_at_press_in;

   logic [7:0] period;
   logic [7:0] on_sel;
   logic [7:0] on_time;
   logic [8:0] phase_plus;
   logic       period_end;
   logic       sample;
   logic       led_on;
   logic [1:0] shown;

   always_comb begin
      period = (cfg.pwm_period < PERIOD_MIN) ? PERIOD_MIN : cfg.pwm_period;
      case (level_ff)
         LEVEL_LOW: on_sel = cfg.on_time_low;
         LEVEL_MID: on_sel = cfg.on_time_mid;
         default:   on_sel = cfg.on_time_high;
      endcase
      on_time    = (on_sel > period) ? period : on_sel;
      phase_plus = {1'b0, phase_ff} + 9'd1;
      period_end = phase_plus >= {1'b0, period};
      sample     = !lit_ff || period_end;
      led_on     = lit_ff && (phase_ff < on_time);
      shown      = (color_ff > COLOR_BLUE) ? COLOR_BLUE : color_ff;

      result.red_on    = led_on && (shown == COLOR_RED);
      result.green_on  = led_on && (shown == COLOR_GREEN);
      result.blue_on   = led_on && (shown == COLOR_BLUE);
      result.out_lit   = lit_ff;
      result.out_color = shown;
      result.out_level = level_ff;
   end

   always_comb begin
      color_in        = color_ff;
      level_in        = level_ff;
      lit_in          = lit_ff;
      phase_in        = phase_ff;
      count_in        = count_ff;
      in_press_in     = in_press_ff;
      accepted_in     = accepted_ff;
      settled_in      = settled_ff;
      lit_at_press_in = lit_at_press_ff;

      if (step_en) begin
         if (lit_ff) begin
            phase_in = period_end ? 8'd0 : phase_plus[7:0];
         end else begin
            phase_in = 8'd0;
         end

         if (sample) begin
            if (button_down) begin
               if (!in_press_ff) begin
                  in_press_in     = 1'b1;
                  count_in        = 6'd0;
                  accepted_in     = 1'b0;
                  settled_in      = 1'b0;
                  lit_at_press_in = lit_ff;
               end
               if (!settled_in) begin
                  if (count_in > cfg.hold_periods) begin
                     if (lit_at_press_in) begin
                        lit_in      = 1'b0;
                        accepted_in = 1'b0;
                     end
                     settled_in = 1'b1;
                  end else if (count_in > cfg.debounce_periods && !accepted_in) begin
                     if (lit_at_press_in) begin
                        accepted_in = 1'b1;
                     end else begin
                        lit_in     = 1'b1;
                        settled_in = 1'b1;
                     end
                  end
                  if (count_in != COUNT_MAX) begin
                     count_in = count_in + 6'd1;
                  end
               end
            end else if (in_press_ff) begin
               in_press_in = 1'b0;
               if (accepted_ff) begin
                  if (level_ff >= LEVEL_HIGH) begin
                     level_in = LEVEL_LOW;
                     color_in = (color_ff >= COLOR_BLUE) ? COLOR_RED : color_ff + 2'd1;
                  end else begin
                     level_in = level_ff + 2'd1;
                  end
               end
               accepted_in = 1'b0;
            end
         end

         if (!lit_in) begin
            phase_in = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff        <= COLOR_RED;
         level_ff        <= LEVEL_LOW;
         lit_ff          <= 1'b1;
         phase_ff        <= 8'd0;
         count_ff        <= 6'd0;
         in_press_ff     <= 1'b0;
         accepted_ff     <= 1'b0;
         settled_ff      <= 1'b0;
         lit_at_press_ff <= 1'b0;
      end else begin
         color_ff        <= color_in;
         level_ff        <= level_in;
         lit_ff          <= lit_in;
         phase_ff        <= phase_in;
         count_ff        <= count_in;
         in_press_ff     <= in_press_in;
         accepted_ff     <= accepted_in;
         settled_ff      <= settled_in;
         lit_at_press_ff <= lit_at_press_in;
      end
   end

endmodule

[design/button_rgb_led_dimmer.sv]
// One-button RGB LED dimmer. Each item on the req_ channel is one millisecond tick carrying
// the button level; each tick yields exactly one rsp_ item with the three LED drives and the
// lit/color/level state as it stood at the start of that tick. A tick is accepted every
// clock cycle while req_stall is low. It waits in an input register, the per-tick PWM and
// press logic runs in a single pass between that register and the result register, and
// the result shows on the rsp_ ports from the result register. A stalled result holds the
// input off only once the input register is also full. Registers on the csr_ port (period,
// three on-times, debounce and hold counts) are always ready and should be written only
// while no ticks are in flight; indexes past the hold count are ignored.
module button_rgb_led_dimmer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_button_down,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_red_on,
   output logic                            rsp_green_on,
   output logic                            rsp_blue_on,
   output logic                            rsp_out_lit,
   output logic [1:0]                      rsp_out_color,
   output logic [1:0]                      rsp_out_level,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [brd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [brd_pkg::CSR_DATA_W-1:0]  csr_data
);
   import brd_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type result_ff;

   logic s1_valid_ff, s1_valid_in;
   logic button_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_take;
   logic s1_move;

   assign req_stall   = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_take    = req_valid && !req_stall;
   assign s1_move     = s1_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign s1_valid_in = req_take || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);

   brd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   brd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (s1_move),
      .button_down (button_ff),
      .cfg         (cfg),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         button_ff <= req_button_down;
      end
      if (s1_move) begin
         result_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_on    = result_ff.red_on;
   assign rsp_green_on  = result_ff.green_on;
   assign rsp_blue_on   = result_ff.blue_on;
   assign rsp_out_lit   = result_ff.out_lit;
   assign rsp_out_color = result_ff.out_color;
   assign rsp_out_level = result_ff.out_level;

endmodule

[design/brd_checker.sv]
`include "button_rgb_led_dimmer_assert.svh"

module brd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_red_on,
   input logic       rsp_green_on,
   input logic       rsp_blue_on,
   input logic       rsp_out_lit,
   input logic [1:0] rsp_out_color,
   input logic [1:0] rsp_out_level
);
   import brd_pkg::*;

   logic       led_ok;
   logic       led_any;
   logic       codes_ok;
   logic [7:0] rsp_item;

   // only the channel of the current color may be driven
   assign led_ok   = (!rsp_red_on || rsp_out_color == COLOR_RED) &&
                     (!rsp_green_on || rsp_out_color == COLOR_GREEN) &&
                     (!rsp_blue_on || rsp_out_color == COLOR_BLUE);
   assign led_any  = rsp_red_on || rsp_green_on || rsp_blue_on;
   assign codes_ok = (rsp_out_color <= COLOR_BLUE) && (rsp_out_level <= LEVEL_HIGH);
   assign rsp_item = {rsp_red_on, rsp_green_on, rsp_blue_on, rsp_out_lit,
                      rsp_out_color, rsp_out_level};

   `BRD_ASSERT_NOW(a_led_color, clock, reset, rsp_valid, led_ok)

   `BRD_ASSERT_NOW(a_dark_off, clock, reset, rsp_valid && !rsp_out_lit, !led_any)

   `BRD_ASSERT_NOW(a_codes, clock, reset, rsp_valid, codes_ok)

   `BRD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))

   `BRD_ASSERT_NOW(a_req_stall, clock, reset, req_stall, rsp_valid && rsp_stall)

endmodule

bind button_rgb_led_dimmer brd_checker u_brd_checker (.*);
